// ----- sv/kmp_pkg.sv -----
package kmp_pkg;

	// Sizing
	localparam int PATTERN_MAX   = 64;
	localparam int POSITION_BITS = 16;
	localparam int PTR_W         = $clog2(PATTERN_MAX + 1);
	localparam int PADDR_W       = $clog2(PATTERN_MAX);
	localparam int FT_DEPTH      = PATTERN_MAX + 1;
	localparam int TPOS_W        = POSITION_BITS + 1;
	localparam int COUNT_W       = 16;

	localparam logic [PTR_W-1:0]   PTR_FULL  = PTR_W'(PATTERN_MAX);
	localparam logic [TPOS_W-1:0]  TPOS_MAX  = {TPOS_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Opcodes
	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_TEXT    = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SHORT    = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic walk;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_more;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- sv/kmp_if.sv -----
interface kmp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, opcode, data_byte, last, input ready);
	modport sink (input valid, opcode, data_byte, last, output ready);
endinterface

interface kmp_result_if;
	logic        valid;
	logic        ready;
	logic        match_found;
	logic [15:0] match_start;
	logic [15:0] match_count;
	logic        text_done;
	logic [1:0]  status;

	modport source (output valid, match_found, match_start, match_count, text_done, status,
		input ready);
	modport sink (input valid, match_found, match_start, match_count, text_done, status,
		output ready);
endinterface

// ----- sv/kmp_ram.sv -----
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/kmp_ctrl.sv -----
module kmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kmp_pkg::dp_stat_t   stat,
	output kmp_pkg::ctrl_cmd_t  cmd
);
	import kmp_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic state_q;
	logic state_d;

	// Take an item in idle, walk the failure chain, then commit once the output slot is free
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.walk_more) begin
					cmd.walk = 1'b1;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/kmp_dp.sv -----
module kmp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  kmp_pkg::ctrl_cmd_t  cmd,
	output kmp_pkg::dp_stat_t   stat,
	input  logic [1:0]          opcode,
	input  logic [7:0]          data_byte,
	input  logic                last,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                match_found,
	output logic [15:0]         match_start,
	output logic [15:0]         match_count,
	output logic                text_done,
	output logic [1:0]          status
);
	import kmp_pkg::*;

	// Search state
	logic [PTR_W-1:0]   len_q, bp_q, mp_q, k_q;
	logic [TPOS_W-1:0]  tpos_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               ovf_q;

	// Latched item
	logic [1:0] op_q;
	logic [7:0] c_q;
	logic       last_q;

	// Result register
	logic                     out_valid_q;
	logic                     found_q, done_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [COUNT_W-1:0]       count_q;
	logic [1:0]               status_q;

	// Memory ports
	logic [PTR_W-1:0] raddr;
	logic [7:0]       pat_rd;
	logic [PTR_W-1:0] fail_rd;
	logic             pat_we, fail_we;

	// Walk and finish terms
	logic                     full, hit, has_pat, found;
	logic [PTR_W-1:0]         t;
	logic [PTR_W-1:0]         mp_new;
	logic [TPOS_W-1:0]        tpos_new;
	logic [COUNT_W-1:0]       cnt_new;
	logic [POSITION_BITS-1:0] start_new;
	logic [1:0]               status_new;

	// Pick the read address: start pointer on accept, failure link on a walk step, chain pointer otherwise
	always_comb begin
		if (cmd.accept) begin
			raddr = (opcode == OP_PATTERN) ? bp_q : mp_q;
		end else if (cmd.walk) begin
			raddr = fail_rd;
		end else begin
			raddr = k_q;
		end
	end

	assign pat_we  = cmd.accept && (opcode == OP_PATTERN) && (len_q < PTR_FULL);
	assign full    = (len_q >= PTR_FULL);
	assign fail_we = cmd.finish && (op_q == OP_PATTERN) && !full;

	kmp_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (len_q[PADDR_W-1:0]),
		.wdata (data_byte),
		.raddr (raddr[PADDR_W-1:0]),
		.rdata (pat_rd)
	);

	kmp_ram #(.WIDTH(PTR_W), .DEPTH(FT_DEPTH)) u_fail_ram (
		.clk   (clk),
		.we    (fail_we),
		.waddr (PTR_W'(len_q + 1'b1)),
		.wdata (t),
		.raddr (raddr),
		.rdata (fail_rd)
	);

	// Compare the pattern byte at the pointer; extend on a hit, follow the link otherwise
	assign hit = (k_q < len_q) && (pat_rd == c_q);
	assign t   = hit ? PTR_W'(k_q + 1'b1) : k_q;

	assign stat.walk_more = (((op_q == OP_PATTERN) && !full) || (op_q == OP_TEXT))
		&& !hit && (k_q != '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	// Text step results
	assign has_pat   = (len_q != '0);
	assign found     = has_pat && (t == len_q);
	assign mp_new    = found ? bp_q : (has_pat ? t : mp_q);
	assign tpos_new  = (tpos_q != TPOS_MAX) ? TPOS_W'(tpos_q + 1'b1) : tpos_q;
	assign cnt_new   = (found && (cnt_q != COUNT_MAX)) ? COUNT_W'(cnt_q + 1'b1) : cnt_q;
	assign start_new = tpos_q[POSITION_BITS-1:0] + POSITION_BITS'(1)
		- POSITION_BITS'(len_q);

	always_comb begin
		if (ovf_q) begin
			status_new = STAT_OVERFLOW;
		end else if (!has_pat) begin
			status_new = STAT_EMPTY;
		end else if (tpos_new < TPOS_W'(len_q)) begin
			status_new = STAT_SHORT;
		end else begin
			status_new = STAT_OK;
		end
	end

	// Latch the item and advance the chain pointer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			c_q    <= data_byte;
			last_q <= last;
			k_q    <= raddr;
		end else if (cmd.walk) begin
			k_q    <= raddr;
		end
	end

	// Commit search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			bp_q   <= '0;
			mp_q   <= '0;
			tpos_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.finish) begin
			case (op_q)
				OP_CLEAR: begin
					len_q  <= '0;
					bp_q   <= '0;
					mp_q   <= '0;
					tpos_q <= '0;
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
				end
				OP_PATTERN: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						bp_q  <= t;
						len_q <= PTR_W'(len_q + 1'b1);
					end
				end
				OP_TEXT: begin
					if (last_q) begin
						mp_q   <= '0;
						tpos_q <= '0;
						cnt_q  <= '0;
					end else begin
						mp_q   <= mp_new;
						tpos_q <= tpos_new;
						cnt_q  <= cnt_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output valid: set on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; all zero except for a text byte
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (op_q == OP_TEXT) begin
				found_q  <= found;
				start_q  <= found ? start_new : '0;
				count_q  <= cnt_new;
				done_q   <= last_q;
				status_q <= last_q ? status_new : STAT_OK;
			end else begin
				found_q  <= 1'b0;
				start_q  <= '0;
				count_q  <= '0;
				done_q   <= 1'b0;
				status_q <= STAT_OK;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = found_q;
	assign match_start = start_q;
	assign match_count = count_q;
	assign text_done   = done_q;
	assign status      = status_q;

endmodule

// ----- sv/kmp_substring_matcher_unit.sv -----
// A result is registered when its item commits, which follows any failure-chain steps and waits
// until the output register is free or is being emptied.
// A new item is taken only after the previous item has committed its result.
// An item is taken while the previous result still waits in the output register.
// Reset clears pattern length, start and match pointers, text position, count and overflow flag
// at once; the pattern and failure memories are not cleared and hold nothing valid until written.
module kmp_substring_matcher_unit (
	input logic         clk,
	input logic         arst_n,
	kmp_item_if.sink    item,
	kmp_result_if.source result
);
	import kmp_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kmp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (item.opcode),
		.data_byte   (item.data_byte),
		.last        (item.last),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.match_found (result.match_found),
		.match_start (result.match_start),
		.match_count (result.match_count),
		.text_done   (result.text_done),
		.status      (result.status)
	);

endmodule
